FILE: rtl/tkm_pkg.sv
// shared types, constants and the ordering compare for the timestamp merge core
package tkm_pkg;

   // default number of source slots
   localparam int MAX_SOURCES_DEF = 16;

   // field widths
   localparam int SOURCE_W = 4;
   localparam int TS_W     = 64;
   localparam int WORD_W   = 32;
   localparam int SIDE_W   = 8;
   localparam int STATUS_W = 2;

   // command codes
   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_POP  = 1'b1;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_REFUSED = 2'd2;

   // one pending head record with its source slot
   typedef struct packed {
      logic        [SOURCE_W-1:0] source;
      logic signed [WORD_W-1:0]   symbol_key;
      logic signed [TS_W-1:0]     timestamp;
      logic signed [WORD_W-1:0]   bid_price;
      logic signed [WORD_W-1:0]   bid_size;
      logic signed [WORD_W-1:0]   ask_price;
      logic signed [WORD_W-1:0]   ask_size;
      logic        [SIDE_W-1:0]   side_code;
   } record_type;

   // per-cycle command broadcast to every cell
   typedef struct packed {
      logic push;
      logic pop;
   } cell_ctrl_type;

   // merge order: signed timestamp, then lower source first
   function automatic logic rec_less(input record_type a, input record_type b);
      logic ts_lt;
      logic ts_eq;
      ts_lt = a.timestamp < b.timestamp;
      ts_eq = a.timestamp == b.timestamp;
      return ts_lt || (ts_eq && (a.source < b.source));
   endfunction

endpackage

FILE: rtl/tkm_cell.sv
// one cell of the sorted record chain: holds one record, shifts on insert and pop
module tkm_cell
   import tkm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  record_type    new_rec,
   input  logic          prev_lt,
   input  logic          prev_valid,
   input  record_type    prev_rec,
   input  logic          next_valid,
   input  record_type    next_rec,
   output logic          own_lt,
   output logic          valid,
   output record_type    rec
);

   logic       valid_ff;
   logic       valid_in;
   record_type rec_ff;
   record_type rec_in;

   // new record belongs ahead of this cell's record (empty cells sort last)
   assign own_lt = !valid_ff || rec_less(new_rec, rec_ff);

   // insert: take left neighbor if the new record lands further left,
   // take the new record if it lands here; pop: take right neighbor
   always_comb begin
      valid_in = valid_ff;
      rec_in   = rec_ff;
      if (ctrl.push) begin
         if (prev_lt) begin
            valid_in = prev_valid;
            rec_in   = prev_rec;
         end else if (own_lt) begin
            valid_in = 1'b1;
            rec_in   = new_rec;
         end
      end else if (ctrl.pop) begin
         valid_in = next_valid;
         rec_in   = next_rec;
      end
   end

   // occupancy flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // record payload
   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

   assign valid = valid_ff;
   assign rec   = rec_ff;

endmodule

FILE: rtl/timestamp_k_way_merge_core.sv
// top level of the timestamp merge core: slot flags, sorted cell chain, response register
//
//   channel   direction  handshake            payload
//   request   in         req_start, busy      req_command .. req_side_code
//   response  out        rsp_strobe (1 cycle) rsp_record_valid .. rsp_popped_count
//
// one request per cycle while busy is low; its response shows on the cycle after acceptance
// the cell chain keeps records sorted, so the smallest is always in the first cell
// insert and pop each work by broadcast compare and neighbor shift
// busy is set during reset and cleared once reset is released; reset empties every slot and the count
// the receiver cannot stall: every response is shown for exactly one cycle
module timestamp_k_way_merge_core
   import tkm_pkg::*;
#(
   parameter int MAX_SOURCES = MAX_SOURCES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_start,
   output logic                       busy,
   input  logic                       req_command,
   input  logic        [SOURCE_W-1:0] req_source,
   input  logic signed [WORD_W-1:0]   req_symbol_key,
   input  logic signed [TS_W-1:0]     req_timestamp,
   input  logic signed [WORD_W-1:0]   req_bid_price,
   input  logic signed [WORD_W-1:0]   req_bid_size,
   input  logic signed [WORD_W-1:0]   req_ask_price,
   input  logic signed [WORD_W-1:0]   req_ask_size,
   input  logic        [SIDE_W-1:0]   req_side_code,
   output logic                       rsp_strobe,
   output logic                       rsp_record_valid,
   output logic        [STATUS_W-1:0] rsp_status,
   output logic        [SOURCE_W-1:0] rsp_out_source,
   output logic signed [WORD_W-1:0]   rsp_out_symbol_key,
   output logic signed [TS_W-1:0]     rsp_out_timestamp,
   output logic signed [WORD_W-1:0]   rsp_out_bid_price,
   output logic signed [WORD_W-1:0]   rsp_out_bid_size,
   output logic signed [WORD_W-1:0]   rsp_out_ask_price,
   output logic signed [WORD_W-1:0]   rsp_out_ask_size,
   output logic        [SIDE_W-1:0]   rsp_out_side_code,
   output logic        [WORD_W-1:0]   rsp_popped_count
);

   localparam int IDX_W = $clog2(MAX_SOURCES);

   logic                   busy_ff;
   logic [MAX_SOURCES-1:0] occ_ff;
   logic [MAX_SOURCES-1:0] occ_in;
   logic [WORD_W-1:0]      cnt_ff;
   logic [WORD_W-1:0]      cnt_in;

   logic                   strobe_ff;
   logic                   rec_valid_ff;
   logic                   rec_valid_in;
   logic [STATUS_W-1:0]    status_ff;
   logic [STATUS_W-1:0]    status_in;
   record_type             out_rec_ff;
   record_type             out_rec_in;

   logic                   accept;
   logic                   src_in_range;
   logic [IDX_W-1:0]       push_idx;
   logic [IDX_W-1:0]       pop_idx;
   logic                   push_ok;
   logic                   pop_hit;
   record_type             new_rec;
   cell_ctrl_type          ctrl;

   logic       [MAX_SOURCES-1:0] cell_valid;
   logic       [MAX_SOURCES-1:0] cell_lt;
   record_type                   cell_rec [MAX_SOURCES];

   assign accept = req_start && !busy_ff;

   // incoming record
   always_comb begin
      new_rec.source     = req_source;
      new_rec.symbol_key = req_symbol_key;
      new_rec.timestamp  = req_timestamp;
      new_rec.bid_price  = req_bid_price;
      new_rec.bid_size   = req_bid_size;
      new_rec.ask_price  = req_ask_price;
      new_rec.ask_size   = req_ask_size;
      new_rec.side_code  = req_side_code;
   end

   // push admission against the slot flags
   assign src_in_range = {{(32-SOURCE_W){1'b0}}, req_source} < 32'(MAX_SOURCES);
   assign push_idx     = IDX_W'(req_source);
   assign pop_idx      = IDX_W'(cell_rec[0].source);
   assign push_ok      = accept && (req_command == CMD_PUSH) && src_in_range
                         && !occ_ff[push_idx];
   assign pop_hit      = accept && (req_command == CMD_POP) && cell_valid[0];

   assign ctrl.push = push_ok;
   assign ctrl.pop  = pop_hit;

   // sorted record chain
   genvar gi;
   generate
      for (gi = 0; gi < MAX_SOURCES; gi++) begin : g_cell
         logic       prev_lt;
         logic       prev_valid;
         record_type prev_rec;
         logic       next_valid;
         record_type next_rec;

         if (gi == 0) begin : g_first
            assign prev_lt    = 1'b0;
            assign prev_valid = 1'b0;
            assign prev_rec   = '0;
         end else begin : g_mid
            assign prev_lt    = cell_lt[gi-1];
            assign prev_valid = cell_valid[gi-1];
            assign prev_rec   = cell_rec[gi-1];
         end

         if (gi == MAX_SOURCES - 1) begin : g_last
            assign next_valid = 1'b0;
            assign next_rec   = '0;
         end else begin : g_body
            assign next_valid = cell_valid[gi+1];
            assign next_rec   = cell_rec[gi+1];
         end

         tkm_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .new_rec    (new_rec),
            .prev_lt    (prev_lt),
            .prev_valid (prev_valid),
            .prev_rec   (prev_rec),
            .next_valid (next_valid),
            .next_rec   (next_rec),
            .own_lt     (cell_lt[gi]),
            .valid      (cell_valid[gi]),
            .rec        (cell_rec[gi])
         );
      end
   endgenerate

   // slot flags, pop count and response contents
   always_comb begin
      occ_in       = occ_ff;
      cnt_in       = cnt_ff;
      rec_valid_in = 1'b0;
      status_in    = ST_OK;
      out_rec_in   = '0;
      if (push_ok) begin
         occ_in[push_idx] = 1'b1;
      end
      if (pop_hit) begin
         occ_in[pop_idx] = 1'b0;
         cnt_in          = cnt_ff + 1'b1;
         rec_valid_in    = 1'b1;
         out_rec_in      = cell_rec[0];
      end
      if (req_command == CMD_PUSH) begin
         status_in = push_ok ? ST_OK : ST_REFUSED;
      end else begin
         status_in = cell_valid[0] ? ST_OK : ST_EMPTY;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b1;
         occ_ff    <= '0;
         cnt_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         busy_ff   <= 1'b0;
         occ_ff    <= occ_in;
         cnt_ff    <= cnt_in;
         strobe_ff <= accept;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         rec_valid_ff <= rec_valid_in;
         status_ff    <= status_in;
         out_rec_ff   <= out_rec_in;
      end
   end

   assign busy               = busy_ff;
   assign rsp_strobe         = strobe_ff;
   assign rsp_record_valid   = rec_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_out_source     = out_rec_ff.source;
   assign rsp_out_symbol_key = out_rec_ff.symbol_key;
   assign rsp_out_timestamp  = out_rec_ff.timestamp;
   assign rsp_out_bid_price  = out_rec_ff.bid_price;
   assign rsp_out_bid_size   = out_rec_ff.bid_size;
   assign rsp_out_ask_price  = out_rec_ff.ask_price;
   assign rsp_out_ask_size   = out_rec_ff.ask_size;
   assign rsp_out_side_code  = out_rec_ff.side_code;
   assign rsp_popped_count   = cnt_ff;

   // chain holds exactly the records that the slot flags mark
   a_occ_count : assert property (@(posedge clock) disable iff (reset)
      $countones(occ_ff) == $countones(cell_valid))
      else $error("slot flags and chain occupancy disagree");

   // the head cell is occupied whenever the second cell is
   a_head_valid : assert property (@(posedge clock) disable iff (reset)
      cell_valid[1] |-> cell_valid[0])
      else $error("chain has a gap at its head");

   // a response comes only after an accepted request
   a_rsp_follows : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept))
      else $error("response without request");

   // a successful pop bumps the count by one
   a_pop_count : assert property (@(posedge clock) disable iff (reset)
      pop_hit |=> cnt_ff == $past(cnt_ff) + 1'b1)
      else $error("pop count not advanced");

endmodule

FILE: test/timestamp_k_way_merge_core_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for the timestamp merge core: directed and random push and pop requests
module timestamp_k_way_merge_core_tb;
   import tkm_pkg::*;

   localparam int NUM_SLOTS       = MAX_SOURCES_DEF;
   localparam int RANDOM_REQUESTS = 1300;
   localparam int CYCLE_LIMIT     = 200000;
   localparam int MAX_REPORTS     = 40;

   // one response as the core shows it
   typedef struct packed {
      logic                record_valid;
      logic [STATUS_W-1:0] status;
      record_type          rec;
      logic [WORD_W-1:0]   popped_count;
   } merge_result_type;

   // slot store and pop count of the core, plus the responses still to come
   class merge_scoreboard;
      logic             slot_full [NUM_SLOTS];
      record_type       slot_rec [NUM_SLOTS];
      logic [WORD_W-1:0] pop_count;
      merge_result_type predicted_results [$];
      int unsigned      errors;

      function new();
         for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_full[i] = 1'b0;
            slot_rec[i]  = '0;
         end
         pop_count = '0;
         errors    = 0;
      endfunction

      function int pending();
         return predicted_results.size();
      endfunction

      // work out the response of one accepted request and update the store
      function void note_request(logic cmd, record_type req);
         merge_result_type res;
         int best;
         res  = '0;
         best = -1;
         if (cmd == CMD_PUSH) begin
            if (int'(req.source) >= NUM_SLOTS || slot_full[req.source]) begin
               res.status = ST_REFUSED;
            end else begin
               slot_full[req.source] = 1'b1;
               slot_rec[req.source]  = req;
               res.status = ST_OK;
            end
         end else begin
            // smallest signed timestamp, lowest slot on a tie
            for (int i = 0; i < NUM_SLOTS; i++) begin
               if (slot_full[i] && (best < 0 ||
                   $signed(slot_rec[i].timestamp) < $signed(slot_rec[best].timestamp)))
                  best = i;
            end
            if (best < 0) begin
               res.status = ST_EMPTY;
            end else begin
               slot_full[best]  = 1'b0;
               pop_count        = pop_count + 1'b1;
               res.record_valid = 1'b1;
               res.status       = ST_OK;
               res.rec          = slot_rec[best];
               res.rec.source   = SOURCE_W'(best);
            end
         end
         res.popped_count = pop_count;
         predicted_results.insert(predicted_results.size(), res);
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] got);
         if (got !== want) begin
            if (errors < MAX_REPORTS)
               $display("%0t mismatch %s: expected %h actual %h", $time, name, want, got);
            errors++;
         end
      endfunction

      // compare one response with the oldest prediction
      function void check_result(merge_result_type got);
         merge_result_type want;
         if (predicted_results.size() == 0) begin
            if (errors < MAX_REPORTS)
               $display("%0t unexpected response: expected none actual %h", $time, got);
            errors++;
            return;
         end
         want = predicted_results.pop_front();
         compare_field("record_valid", 64'(want.record_valid), 64'(got.record_valid));
         compare_field("status", 64'(want.status), 64'(got.status));
         compare_field("out_source", 64'(want.rec.source), 64'(got.rec.source));
         compare_field("out_symbol_key", 64'(want.rec.symbol_key), 64'(got.rec.symbol_key));
         compare_field("out_timestamp", want.rec.timestamp, got.rec.timestamp);
         compare_field("out_bid_price", 64'(want.rec.bid_price), 64'(got.rec.bid_price));
         compare_field("out_bid_size", 64'(want.rec.bid_size), 64'(got.rec.bid_size));
         compare_field("out_ask_price", 64'(want.rec.ask_price), 64'(got.rec.ask_price));
         compare_field("out_ask_size", 64'(want.rec.ask_size), 64'(got.rec.ask_size));
         compare_field("out_side_code", 64'(want.rec.side_code), 64'(got.rec.side_code));
         compare_field("popped_count", 64'(want.popped_count), 64'(got.popped_count));
      endfunction
   endclass

   logic                       clock;
   logic                       reset;
   logic                       req_start;
   logic                       busy;
   logic                       req_command;
   logic        [SOURCE_W-1:0] req_source;
   logic signed [WORD_W-1:0]   req_symbol_key;
   logic signed [TS_W-1:0]     req_timestamp;
   logic signed [WORD_W-1:0]   req_bid_price;
   logic signed [WORD_W-1:0]   req_bid_size;
   logic signed [WORD_W-1:0]   req_ask_price;
   logic signed [WORD_W-1:0]   req_ask_size;
   logic        [SIDE_W-1:0]   req_side_code;
   logic                       rsp_strobe;
   logic                       rsp_record_valid;
   logic        [STATUS_W-1:0] rsp_status;
   logic        [SOURCE_W-1:0] rsp_out_source;
   logic signed [WORD_W-1:0]   rsp_out_symbol_key;
   logic signed [TS_W-1:0]     rsp_out_timestamp;
   logic signed [WORD_W-1:0]   rsp_out_bid_price;
   logic signed [WORD_W-1:0]   rsp_out_bid_size;
   logic signed [WORD_W-1:0]   rsp_out_ask_price;
   logic signed [WORD_W-1:0]   rsp_out_ask_size;
   logic        [SIDE_W-1:0]   rsp_out_side_code;
   logic        [WORD_W-1:0]   rsp_popped_count;

   merge_scoreboard sb = new();
   int  cycle_count = 0;
   bit  gaps_on = 1'b1;

   timestamp_k_way_merge_core #(
      .MAX_SOURCES(NUM_SLOTS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_start(req_start),
      .busy(busy),
      .req_command(req_command),
      .req_source(req_source),
      .req_symbol_key(req_symbol_key),
      .req_timestamp(req_timestamp),
      .req_bid_price(req_bid_price),
      .req_bid_size(req_bid_size),
      .req_ask_price(req_ask_price),
      .req_ask_size(req_ask_size),
      .req_side_code(req_side_code),
      .rsp_strobe(rsp_strobe),
      .rsp_record_valid(rsp_record_valid),
      .rsp_status(rsp_status),
      .rsp_out_source(rsp_out_source),
      .rsp_out_symbol_key(rsp_out_symbol_key),
      .rsp_out_timestamp(rsp_out_timestamp),
      .rsp_out_bid_price(rsp_out_bid_price),
      .rsp_out_bid_size(rsp_out_bid_size),
      .rsp_out_ask_price(rsp_out_ask_price),
      .rsp_out_ask_size(rsp_out_ask_size),
      .rsp_out_side_code(rsp_out_side_code),
      .rsp_popped_count(rsp_popped_count)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // note accepted requests, then check the response of the cycle
   always @(posedge clock) begin
      merge_result_type got;
      record_type req;
      if (!reset) begin
         if (req_start && !busy) begin
            req = '{req_source, req_symbol_key, req_timestamp, req_bid_price,
                    req_bid_size, req_ask_price, req_ask_size, req_side_code};
            sb.note_request(req_command, req);
         end
         if (rsp_strobe) begin
            got = '{rsp_record_valid, rsp_status,
                    '{rsp_out_source, rsp_out_symbol_key, rsp_out_timestamp,
                      rsp_out_bid_price, rsp_out_bid_size, rsp_out_ask_price,
                      rsp_out_ask_size, rsp_out_side_code},
                    rsp_popped_count};
            sb.check_result(got);
         end
      end
   end

   // record with random payload at a given slot and time
   function automatic record_type make_record(logic [SOURCE_W-1:0] src,
                                              logic [TS_W-1:0] ts);
      record_type r;
      r.source     = src;
      r.symbol_key = $urandom;
      r.timestamp  = ts;
      r.bid_price  = $urandom;
      r.bid_size   = $urandom;
      r.ask_price  = $urandom;
      r.ask_size   = $urandom;
      r.side_code  = $urandom;
      return r;
   endfunction

   function automatic logic [TS_W-1:0] random_time();
      logic [TS_W-1:0] ts;
      case ($urandom_range(0, 9))
         0: ts = {1'b0, {(TS_W-1){1'b1}}};
         1: ts = {1'b1, {(TS_W-1){1'b0}}};
         // narrow band around zero so that ties and sign flips are common
         2, 3, 4: ts = 64'($urandom_range(0, 7)) - 64'd4;
         default: ts = {$urandom, $urandom};
      endcase
      return ts;
   endfunction

   // drive payload fields, with start held as given
   task automatic drive_fields(logic start, logic cmd, record_type r);
      req_start      <= start;
      req_command    <= cmd;
      req_source     <= r.source;
      req_symbol_key <= r.symbol_key;
      req_timestamp  <= r.timestamp;
      req_bid_price  <= r.bid_price;
      req_bid_size   <= r.bid_size;
      req_ask_price  <= r.ask_price;
      req_ask_size   <= r.ask_size;
      req_side_code  <= r.side_code;
   endtask

   // present one request until accepted, then maybe leave a short gap with noise on the payload
   task automatic send_request(logic cmd, record_type r);
      int gap;
      drive_fields(1'b1, cmd, r);
      @(posedge clock);
      while (busy) @(posedge clock);
      if (gaps_on && $urandom_range(0, 99) < 10) begin
         gap = $urandom_range(1, 2);
         repeat (gap) begin
            drive_fields(1'b0, 1'($urandom), make_record(4'($urandom), {$urandom, $urandom}));
            @(posedge clock);
         end
      end
   endtask

   task automatic push_record(logic [SOURCE_W-1:0] src, record_type r);
      r.source = src;
      send_request(CMD_PUSH, r);
   endtask

   task automatic pop_record();
      send_request(CMD_POP, make_record(4'($urandom), {$urandom, $urandom}));
   endtask

   // stimulus
   initial begin
      int pop_pct;
      int free_slots [$];
      record_type r;

      drive_fields(1'b0, CMD_PUSH, '0);
      reset <= 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // pop of an empty store
      pop_record();
      // extreme payloads: largest time with all fields high, smallest with all fields low
      r = '{4'd0, 32'h7fff_ffff, 64'h7fff_ffff_ffff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
            32'h7fff_ffff, 32'h7fff_ffff, 8'hff};
      push_record(4'd0, r);
      r = '{4'd15, 32'h8000_0000, 64'h8000_0000_0000_0000, 32'h8000_0000, 32'h8000_0000,
            32'h8000_0000, 32'h8000_0000, 8'h00};
      push_record(4'd15, r);
      // pushes into occupied slots are refused
      push_record(4'd0, make_record(4'd0, 64'd5));
      push_record(4'd15, make_record(4'd15, 64'd5));
      pop_record();
      pop_record();
      pop_record();
      // equal timestamps go out lowest slot first
      push_record(4'd7, make_record(4'd7, 64'd42));
      push_record(4'd3, make_record(4'd3, 64'd42));
      push_record(4'd12, make_record(4'd12, 64'd42));
      repeat (3) pop_record();
      // signed order around zero
      push_record(4'd5, make_record(4'd5, 64'd0));
      push_record(4'd6, make_record(4'd6, -64'sd1));
      push_record(4'd9, make_record(4'd9, 64'd1));
      repeat (4) pop_record();

      // random mix; the pop share drifts so the store fills up and drains
      pop_pct = 40;
      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         gaps_on = !(i >= 500 && i < 800);
         if (i % 100 == 0)
            pop_pct = $urandom_range(15, 75);
         if ($urandom_range(0, 99) < pop_pct) begin
            pop_record();
         end else begin
            free_slots.delete();
            for (int s = 0; s < NUM_SLOTS; s++)
               if (!sb.slot_full[s]) free_slots.insert(free_slots.size(), s);
            // mostly pushes into free slots, some refused ones
            if (free_slots.size() > 0 && $urandom_range(0, 99) < 85)
               push_record(4'(free_slots[$urandom_range(0, free_slots.size() - 1)]),
                           make_record('0, random_time()));
            else
               push_record(4'($urandom), make_record('0, random_time()));
         end
      end

      // drain
      req_start <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
